// ----- rtl/core/qpool_pkg.sv -----
// ----------------------------------------------------------------------------
// qpool_pkg
// Shared types and constants for the quota pool acquire/release core.
// ----------------------------------------------------------------------------
package qpool_pkg;

   // pool geometry
   localparam int NUM_LIMITERS = 4;
   localparam int COUNT_WIDTH  = 32;

   // field widths
   localparam int AMOUNT_WIDTH = 32;
   localparam int SEL_WIDTH    = 4;
   localparam int STATUS_WIDTH = 2;
   localparam int FAIL_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 8;

   // compare width, wide enough for both a count and an amount
   localparam int CMP_WIDTH = (COUNT_WIDTH > AMOUNT_WIDTH) ? COUNT_WIDTH : AMOUNT_WIDTH;

   typedef enum logic {
      FUNC_ACQUIRE = 1'b0,
      FUNC_RELEASE = 1'b1
   } qpool_func_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_DONE      = 2'd0,
      ST_REFUSED   = 2'd1,
      ST_SATURATED = 2'd2
   } qpool_status_type;

   // register index (byte address bits [4:2])
   typedef enum logic [2:0] {
      REG_LIMIT_ZERO  = 3'd0,
      REG_LIMIT_ONE   = 3'd1,
      REG_LIMIT_TWO   = 3'd2,
      REG_LIMIT_THREE = 3'd3,
      REG_BYPASS_MASK = 3'd4
   } qpool_reg_type;

   // operation broadcast to every limiter lane
   typedef struct packed {
      logic                    apply;
      qpool_func_type          func;
      logic [AMOUNT_WIDTH-1:0] amount;
   } qpool_op_type;

   // per-lane check results
   typedef struct packed {
      logic short_credit;
      logic would_saturate;
   } qpool_lane_stat_type;

endpackage

// ----- rtl/core/quota_pool_acquire_release_core.sv -----
// ----------------------------------------------------------------------------
// quota_pool_acquire_release_core
// Pool of quota counters with all-or-nothing acquire and saturating release.
// ----------------------------------------------------------------------------
// Each request is held in the input register and its result in the result register.
// Throughput: one request per cycle while the response is not stalled; the
// counter read-modify-write of all limiters is done from the input register.
// Reset clears all limits, available counts, the bypass mask and all valid
// flags; the block accepts requests in the first cycle after reset.
module quota_pool_acquire_release_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: amount[31:0], member_mask[35:32], zero pad[39:36]
   input  logic [qpool_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // tuser: func[0]
   input  logic                                 req_tuser,
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata: status[1:0], failed_index[3:2], zero pad[7:4]
   output logic [qpool_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [qpool_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [qpool_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [qpool_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);

   localparam int NL = qpool_pkg::NUM_LIMITERS;

   // input register
   logic                                 s1_valid_ff, s1_valid_in;
   qpool_pkg::qpool_func_type            s1_func_ff;
   logic [qpool_pkg::AMOUNT_WIDTH-1:0]   s1_amount_ff;
   logic [qpool_pkg::SEL_WIDTH-1:0]      s1_mask_ff;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   qpool_pkg::qpool_status_type          rsp_status_ff, rsp_status_in;
   logic [qpool_pkg::FAIL_WIDTH-1:0]     rsp_failed_ff, rsp_failed_in;

   logic [qpool_pkg::SEL_WIDTH-1:0]      bypass_ff, bypass_in;

   logic                                 advance;
   logic                                 fire;
   logic                                 req_accept;
   logic                                 csr_wr;
   qpool_pkg::qpool_reg_type             reg_idx;
   logic                                 refused;
   logic                                 any_sat;

   logic [NL-1:0]                        active;
   logic [NL-1:0]                        lane_wr;
   qpool_pkg::qpool_lane_stat_type       lane_stat [NL];
   qpool_pkg::qpool_op_type              lane_op   [NL];
   logic [qpool_pkg::COUNT_WIDTH-1:0]    lane_limit [NL];
   logic [qpool_pkg::CSR_DATA_WIDTH-1:0] limit_rd  [qpool_pkg::SEL_WIDTH];
   logic [qpool_pkg::COUNT_WIDTH-1:0]    wr_count;

   // handshake
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign fire       = s1_valid_ff && advance;
   assign req_accept = req_tvalid && req_tready;

   // configuration decode
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = qpool_pkg::qpool_reg_type'(csr_paddr[4:2]);
   assign wr_count   = qpool_pkg::COUNT_WIDTH'(qpool_pkg::CMP_WIDTH'(csr_pwdata));

   always_comb begin
      bypass_in = bypass_ff;
      if (csr_wr && (reg_idx == qpool_pkg::REG_BYPASS_MASK)) begin
         bypass_in = csr_pwdata[qpool_pkg::SEL_WIDTH-1:0];
      end
   end

   // register readback
   always_comb begin
      unique case (reg_idx)
         qpool_pkg::REG_LIMIT_ZERO:  csr_prdata = limit_rd[0];
         qpool_pkg::REG_LIMIT_ONE:   csr_prdata = limit_rd[1];
         qpool_pkg::REG_LIMIT_TWO:   csr_prdata = limit_rd[2];
         qpool_pkg::REG_LIMIT_THREE: csr_prdata = limit_rd[3];
         qpool_pkg::REG_BYPASS_MASK:
            csr_prdata = qpool_pkg::CSR_DATA_WIDTH'(bypass_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // limiter lanes
   for (genvar g = 0; g < NL; g++) begin : g_lane
      if (g < qpool_pkg::SEL_WIDTH) begin : g_sel
         assign active[g]  = s1_mask_ff[g] && !bypass_ff[g];
         assign lane_wr[g] = csr_wr && (reg_idx == qpool_pkg::qpool_reg_type'(3'(g)));
      end else begin : g_unsel
         assign active[g]  = 1'b0;
         assign lane_wr[g] = 1'b0;
      end

      assign lane_op[g].apply  = fire && active[g] &&
                                 ((s1_func_ff == qpool_pkg::FUNC_RELEASE) || !refused);
      assign lane_op[g].func   = s1_func_ff;
      assign lane_op[g].amount = s1_amount_ff;

      qpool_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .wr_en       (lane_wr[g]),
         .wr_data     (wr_count),
         .op          (lane_op[g]),
         .stat        (lane_stat[g]),
         .limit_value (lane_limit[g])
      );
   end

   // limit readback per register slot
   for (genvar k = 0; k < qpool_pkg::SEL_WIDTH; k++) begin : g_rd
      if (k < NL) begin : g_have
         assign limit_rd[k] =
            qpool_pkg::CSR_DATA_WIDTH'(qpool_pkg::CMP_WIDTH'(lane_limit[k]));
      end else begin : g_none
         assign limit_rd[k] = '0;
      end
   end

   // refusal, lowest failing limiter and saturation
   always_comb begin
      refused       = 1'b0;
      any_sat       = 1'b0;
      rsp_failed_in = '0;
      for (int i = NL - 1; i >= 0; i--) begin
         if (active[i] && lane_stat[i].short_credit) begin
            refused       = 1'b1;
            rsp_failed_in = qpool_pkg::FAIL_WIDTH'(i);
         end
         if (active[i] && lane_stat[i].would_saturate) begin
            any_sat = 1'b1;
         end
      end
   end

   // result status
   always_comb begin
      rsp_status_in = qpool_pkg::ST_DONE;
      if (s1_func_ff == qpool_pkg::FUNC_ACQUIRE) begin
         if (refused) begin
            rsp_status_in = qpool_pkg::ST_REFUSED;
         end
      end else if (any_sat) begin
         rsp_status_in = qpool_pkg::ST_SATURATED;
      end
   end

   // valid flags
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bypass_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bypass_ff    <= bypass_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff   <= qpool_pkg::qpool_func_type'(req_tuser);
         s1_amount_ff <= req_tdata[31:0];
         s1_mask_ff   <= req_tdata[35:32];
      end
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_failed_ff <= (rsp_status_in == qpool_pkg::ST_REFUSED) ? rsp_failed_in : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_failed_ff, rsp_status_ff};

endmodule

// ----- rtl/core/qpool_lane.sv -----
// ----------------------------------------------------------------------------
// qpool_lane
// One limiter: holds its limit and available count, checks a request
// against them and applies the committed update.
// ----------------------------------------------------------------------------
module qpool_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [qpool_pkg::COUNT_WIDTH-1:0] wr_data,
   input  qpool_pkg::qpool_op_type           op,
   output qpool_pkg::qpool_lane_stat_type    stat,
   output logic [qpool_pkg::COUNT_WIDTH-1:0] limit_value
);

   logic [qpool_pkg::COUNT_WIDTH-1:0] limit_ff;
   logic [qpool_pkg::COUNT_WIDTH-1:0] limit_in;
   logic [qpool_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [qpool_pkg::COUNT_WIDTH-1:0] count_in;
   logic [qpool_pkg::COUNT_WIDTH-1:0] headroom;
   logic [qpool_pkg::CMP_WIDTH-1:0]   avail_ext;
   logic [qpool_pkg::CMP_WIDTH-1:0]   amount_ext;
   logic [qpool_pkg::CMP_WIDTH-1:0]   sum_ext;

   // checks against the current count
   always_comb begin
      avail_ext  = qpool_pkg::CMP_WIDTH'(count_ff);
      amount_ext = qpool_pkg::CMP_WIDTH'(op.amount);
      headroom   = (limit_ff >= count_ff) ? (limit_ff - count_ff) : '0;
      sum_ext    = avail_ext + amount_ext;
      stat.short_credit   = (avail_ext < amount_ext);
      stat.would_saturate = (amount_ext > qpool_pkg::CMP_WIDTH'(headroom));
   end

   // next count and limit
   always_comb begin
      limit_in = limit_ff;
      count_in = count_ff;
      if (wr_en) begin
         limit_in = wr_data;
         count_in = wr_data;
      end else if (op.apply) begin
         if (op.func == qpool_pkg::FUNC_ACQUIRE) begin
            count_in = count_ff - amount_ext[qpool_pkg::COUNT_WIDTH-1:0];
         end else if (stat.would_saturate) begin
            count_in = limit_ff;
         end else begin
            count_in = sum_ext[qpool_pkg::COUNT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         count_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         count_ff <= count_in;
      end
   end

   assign limit_value = limit_ff;

endmodule

// ----- rtl/core/qpool_checker.sv -----
// ----------------------------------------------------------------------------
// qpool_checker
// Port-level assertions for the quota pool core, bound to the top level.
// ----------------------------------------------------------------------------
module qpool_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [qpool_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                                 csr_pready
);

   // no result may appear right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // status carries only defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == qpool_pkg::ST_DONE ||
                      rsp_tdata[1:0] == qpool_pkg::ST_REFUSED ||
                      rsp_tdata[1:0] == qpool_pkg::ST_SATURATED))
      else $error("undefined status code");

   // failing index only reported with a refusal
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != qpool_pkg::ST_REFUSED) |-> rsp_tdata[3:2] == 2'b00)
      else $error("failed index set without refusal");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // register port never waits
   assert property (@(posedge clock) csr_pready)
      else $error("pready dropped");

endmodule

bind quota_pool_acquire_release_core qpool_checker u_qpool_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
